>>> src/assert_macros.svh
// =============================================================================
// assert_macros.svh
// shared assertion macros for the block checkers
// =============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

>>> src/mgsp_pkg.sv
// =============================================================================
// mgsp_pkg
// shared widths, register map and reset values of the multistage path solver
// =============================================================================
`default_nettype none

package mgsp_pkg;

    // fixed field widths
    localparam int COST_W     = 16;
    localparam int FIELD_W    = 7;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_STAGE_COUNT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COST_LIMIT  = 2'd2;

    // register reset values
    localparam logic [FIELD_W-1:0] NODE_COUNT_RST  = 7'd64;
    localparam logic [FIELD_W-1:0] STAGE_COUNT_RST = 7'd2;
    localparam logic [COST_W-1:0]  COST_LIMIT_RST  = 16'd100;

endpackage

`default_nettype wire

>>> src/multistage_graph_shortest_path.sv
// =============================================================================
// multistage_graph_shortest_path
// backward dynamic programming shortest path over a node-ordered multistage graph
// =============================================================================
// An edge-write request (action 0) stores one weight as it is accepted; the
// block stays idle and another request can follow in the next cycle. A solve
// request (action 1) holds busy high while the weights are scanned from the
// sink backwards, one candidate edge per cycle through the single read port of
// the weight memory, with a drain step that closes out each node after its
// last candidate; the path is then streamed with a decision read between two
// results. Results appear on result_valid for one cycle each and cannot be
// held off, so the receiver must take them as they come. Graph and per-node
// state live in two memories (weights, and per-node cost/reachable/decision)
// that are never cleared: every weight read by a solve must have been written.
`default_nettype none

module multistage_graph_shortest_path #(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                action,
    input  logic [mgsp_pkg::FIELD_W-1:0]        from_node,
    input  logic [mgsp_pkg::FIELD_W-1:0]        to_node,
    input  logic [WEIGHT_BITS-1:0]              weight,
    // result channel
    output logic                                result_valid,
    output logic [mgsp_pkg::FIELD_W-1:0]        path_node,
    output logic [mgsp_pkg::FIELD_W-1:0]        path_position,
    output logic [mgsp_pkg::COST_W-1:0]         total_cost,
    output logic                                unreachable,
    output logic                                last,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mgsp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mgsp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mgsp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import mgsp_pkg::*;

    // node index width (0-based), count width (holds MAX_NODES itself)
    localparam int NB         = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W      = $clog2(MAX_NODES + 1);
    localparam int EXT_W      = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
    localparam int SUM_W      = ((WEIGHT_BITS > COST_W) ? WEIGHT_BITS : COST_W) + 1;
    localparam int NODE_DEPTH = 1 << NB;
    localparam int WGT_DEPTH  = 1 << (2 * NB);

    // per-node entry of the node memory
    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              ok;
        logic [NB-1:0]     dec;
    } node_ent_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_PATH_RD,
        ST_PATH_OUT
    } state_t;

    // -------------------------------------------------------------------------
    // configuration registers
    // -------------------------------------------------------------------------
    logic [FIELD_W-1:0]   node_count_reg;
    logic [FIELD_W-1:0]   stage_count_reg;
    logic [COST_W-1:0]    cost_limit_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_we;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= NODE_COUNT_RST;
            stage_count_reg <= STAGE_COUNT_RST;
            cost_limit_reg  <= COST_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            // writes beyond the register list are dropped
            unique case (reg_idx)
                REG_NODE_COUNT:  node_count_reg  <= pwdata[FIELD_W-1:0];
                REG_STAGE_COUNT: stage_count_reg <= pwdata[FIELD_W-1:0];
                REG_COST_LIMIT:  cost_limit_reg  <= pwdata[COST_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_NODE_COUNT:  prdata = APB_DATA_W'(node_count_reg);
            REG_STAGE_COUNT: prdata = APB_DATA_W'(stage_count_reg);
            REG_COST_LIMIT:  prdata = APB_DATA_W'(cost_limit_reg);
            default:         prdata = '0;
        endcase
    end

    // -------------------------------------------------------------------------
    // effective counts, saturated to 2..MAX_NODES
    // -------------------------------------------------------------------------
    logic [EXT_W-1:0] nc_ext;
    logic [EXT_W-1:0] sc_ext;
    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] k_eff;
    logic [CNT_W-1:0] sink_m1;
    logic [NB-1:0]    sink;

    assign nc_ext = EXT_W'(node_count_reg);
    assign sc_ext = EXT_W'(stage_count_reg);

    always_comb
    begin
        priority if (nc_ext < EXT_W'(2))
            n_eff = CNT_W'(2);
        else if (nc_ext > EXT_W'(MAX_NODES))
            n_eff = CNT_W'(MAX_NODES);
        else
            n_eff = nc_ext[CNT_W-1:0];

        priority if (sc_ext < EXT_W'(2))
            k_eff = CNT_W'(2);
        else if (sc_ext > EXT_W'(MAX_NODES))
            k_eff = CNT_W'(MAX_NODES);
        else
            k_eff = sc_ext[CNT_W-1:0];
    end

    // sink as a 0-based node index
    assign sink_m1 = n_eff - CNT_W'(1);
    assign sink    = sink_m1[NB-1:0];

    // -------------------------------------------------------------------------
    // control registers
    // -------------------------------------------------------------------------
    state_t             state_reg,   state_next;
    logic [NB-1:0]      j_reg,       j_next;      // node being solved
    logic [NB-1:0]      i_reg,       i_next;      // candidate being fetched
    logic               rd_vld_reg,  rd_vld_next; // a candidate read is in flight
    logic [NB-1:0]      rd_i_reg,    rd_i_next;   // which candidate it is
    logic [COST_W-1:0]  best_reg,    best_next;
    logic               found_reg,   found_next;
    logic [NB-1:0]      pick_reg,    pick_next;
    logic [CNT_W-1:0]   pos_reg,     pos_next;
    logic [NB-1:0]      cur_reg,     cur_next;
    logic               first_reg,   first_next;
    logic [COST_W-1:0]  cost1_reg,   cost1_next;
    logic               unreach_reg, unreach_next;
    logic               rv_reg,      rv_next;
    logic [FIELD_W-1:0] pnode_reg,   pnode_next;
    logic [FIELD_W-1:0] ppos_reg,    ppos_next;
    logic               last_reg,    last_next;

    // -------------------------------------------------------------------------
    // memories
    // -------------------------------------------------------------------------
    logic [WEIGHT_BITS-1:0] wgt_mem [WGT_DEPTH];
    node_ent_t              node_mem [NODE_DEPTH];

    logic                   wgt_we;
    logic [2*NB-1:0]        wgt_waddr;
    logic [2*NB-1:0]        wgt_raddr;
    logic [WEIGHT_BITS-1:0] wgt_q;

    logic                   node_we;
    logic [NB-1:0]          node_waddr;
    node_ent_t              node_wdata;
    logic [NB-1:0]          node_raddr;
    node_ent_t              node_q;

    always_ff @(posedge clk)
    begin
        if (wgt_we)
            wgt_mem[wgt_waddr] <= weight;
        wgt_q <= wgt_mem[wgt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_waddr] <= node_wdata;
        node_q <= node_mem[node_raddr];
    end

    // -------------------------------------------------------------------------
    // request decode
    // -------------------------------------------------------------------------
    logic             accept;
    logic [EXT_W-1:0] from_ext;
    logic [EXT_W-1:0] to_ext;
    logic [EXT_W-1:0] from_m1;
    logic [EXT_W-1:0] to_m1;
    logic             in_range;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign from_ext = EXT_W'(from_node);
    assign to_ext   = EXT_W'(to_node);
    assign from_m1  = from_ext - EXT_W'(1);
    assign to_m1    = to_ext - EXT_W'(1);
    assign in_range = (from_ext != '0) && (from_ext <= EXT_W'(MAX_NODES)) &&
                      (to_ext != '0) && (to_ext <= EXT_W'(MAX_NODES));

    // out-of-range writes are dropped
    assign wgt_we    = accept && !action && in_range;
    assign wgt_waddr = {from_m1[NB-1:0], to_m1[NB-1:0]};
    assign wgt_raddr = {j_reg, i_reg};

    // the node memory is scanned by candidate, then walked by decision
    assign node_raddr = (state_reg == ST_ISSUE) ? i_reg : cur_reg;

    // -------------------------------------------------------------------------
    // candidate compare, on the registered memory reads
    // -------------------------------------------------------------------------
    logic [SUM_W-1:0]  sum;
    logic              take;
    logic [COST_W-1:0] best_upd;
    logic              found_upd;
    logic [NB-1:0]     pick_upd;

    assign sum       = SUM_W'(wgt_q) + SUM_W'(node_q.cost);
    // strict less keeps the first index that reaches the minimum
    assign take      = rd_vld_reg && node_q.ok && (sum < SUM_W'(best_reg));
    assign best_upd  = take ? sum[COST_W-1:0] : best_reg;
    assign found_upd = found_reg || take;
    assign pick_upd  = take ? rd_i_reg : pick_reg;

    // path node at the current position
    logic [NB-1:0] walk_node;
    logic [NB:0]   walk_node1;

    always_comb
    begin
        priority if (pos_reg == k_eff)
            walk_node = sink;
        else if (first_reg)
            walk_node = '0;
        else
            walk_node = node_q.dec;
    end

    assign walk_node1 = {1'b0, walk_node} + (NB + 1)'(1);

    // -------------------------------------------------------------------------
    // sequencer
    // -------------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        j_next       = j_reg;
        i_next       = i_reg;
        rd_vld_next  = 1'b0;
        rd_i_next    = rd_i_reg;
        best_next    = best_reg;
        found_next   = found_reg;
        pick_next    = pick_reg;
        pos_next     = pos_reg;
        cur_next     = cur_reg;
        first_next   = first_reg;
        cost1_next   = cost1_reg;
        unreach_next = unreach_reg;
        rv_next      = 1'b0;
        pnode_next   = pnode_reg;
        ppos_next    = ppos_reg;
        last_next    = last_reg;
        node_we      = 1'b0;
        node_waddr   = j_reg;
        node_wdata   = '{cost: best_upd, ok: 1'b1, dec: pick_upd};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && action)
                begin
                    // seed the sink: cost 0, reachable, decides for itself
                    node_we    = 1'b1;
                    node_waddr = sink;
                    node_wdata = '{cost: '0, ok: 1'b1, dec: sink};
                    j_next     = sink - NB'(1);
                    i_next     = sink;
                    best_next  = cost_limit_reg;
                    found_next = 1'b0;
                    state_next = ST_ISSUE;
                end
            end

            ST_ISSUE:
            begin
                best_next   = best_upd;
                found_next  = found_upd;
                pick_next   = pick_upd;
                rd_vld_next = 1'b1;
                rd_i_next   = i_reg;
                if (i_reg == sink)
                    state_next = ST_DRAIN;
                else
                    i_next = i_reg + NB'(1);
            end

            ST_DRAIN:
            begin
                // last candidate compared, store node j
                node_we = 1'b1;
                if (found_upd)
                    node_wdata = '{cost: best_upd, ok: 1'b1, dec: pick_upd};
                else
                    node_wdata = '{cost: '0, ok: 1'b0, dec: sink};
                best_next  = cost_limit_reg;
                found_next = 1'b0;
                if (j_reg == '0)
                begin
                    cost1_next   = found_upd ? best_upd : '0;
                    unreach_next = !found_upd;
                    pos_next     = CNT_W'(1);
                    cur_next     = '0;
                    first_next   = 1'b1;
                    state_next   = ST_PATH_OUT;
                end
                else
                begin
                    // next node reads the entry just written in the next cycle
                    j_next     = j_reg - NB'(1);
                    i_next     = j_reg;
                    state_next = ST_ISSUE;
                end
            end

            ST_PATH_RD:
            begin
                // decision of cur_reg lands in node_q
                state_next = ST_PATH_OUT;
            end

            ST_PATH_OUT:
            begin
                rv_next    = 1'b1;
                pnode_next = FIELD_W'(walk_node1);
                ppos_next  = FIELD_W'(pos_reg);
                last_next  = (pos_reg == k_eff);
                cur_next   = walk_node;
                first_next = 1'b0;
                if (pos_reg == k_eff)
                    state_next = ST_IDLE;
                else
                begin
                    pos_next   = pos_reg + CNT_W'(1);
                    state_next = ST_PATH_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_vld_reg  <= 1'b0;
            rv_reg      <= 1'b0;
            first_reg   <= 1'b0;
            found_reg   <= 1'b0;
            j_reg       <= '0;
            i_reg       <= '0;
            pos_reg     <= '0;
            cur_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_vld_next;
            rv_reg      <= rv_next;
            first_reg   <= first_next;
            found_reg   <= found_next;
            j_reg       <= j_next;
            i_reg       <= i_next;
            pos_reg     <= pos_next;
            cur_reg     <= cur_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        rd_i_reg    <= rd_i_next;
        best_reg    <= best_next;
        pick_reg    <= pick_next;
        cost1_reg   <= cost1_next;
        unreach_reg <= unreach_next;
        pnode_reg   <= pnode_next;
        ppos_reg    <= ppos_next;
        last_reg    <= last_next;
    end

    // -------------------------------------------------------------------------
    // result ports
    // -------------------------------------------------------------------------
    assign result_valid  = rv_reg;
    assign path_node     = pnode_reg;
    assign path_position = ppos_reg;
    assign total_cost    = cost1_reg;
    assign unreachable   = unreach_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

>>> src/mgsp_checker.sv
// =============================================================================
// mgsp_checker
// port-level checks on the result stream of the multistage path solver
// =============================================================================
`default_nettype none

`include "assert_macros.svh"

module mgsp_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         result_valid,
    input  wire logic [mgsp_pkg::FIELD_W-1:0] path_position,
    input  wire logic [mgsp_pkg::COST_W-1:0]  total_cost,
    input  wire logic                         unreachable,
    input  wire logic                         last
);
    import mgsp_pkg::*;

    // results of one solve never come back to back
    `ASSERT_CLK(a_gap, clk, rst_n, result_valid |=> !result_valid, "results back to back")

    // positions count up by one within a solve
    `ASSERT_CLK(a_pos_step, clk, rst_n, (result_valid && !last) |-> ##2 (result_valid && (path_position == $past(path_position, 2) + FIELD_W'(1))), "path position did not advance by one")

    // cost and reachability are the same on every result of a solve
    `ASSERT_CLK(a_cost_hold, clk, rst_n, (result_valid && !last) |-> ##2 ((total_cost == $past(total_cost, 2)) && (unreachable == $past(unreachable, 2))), "total cost changed within a solve")

    // an unreachable start reports zero cost
    `ASSERT_NEVER(a_unreach_cost, clk, rst_n, result_valid && unreachable && (total_cost != '0), "unreachable result with nonzero cost")

endmodule

bind multistage_graph_shortest_path mgsp_checker u_mgsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .path_position (path_position),
    .total_cost    (total_cost),
    .unreachable   (unreachable),
    .last          (last)
);

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// =============================================================================
// tb_top
// self-checking bench for the multistage graph shortest path solver
// =============================================================================
// Edge-write and solve requests go in over the command channel. The
// configuration registers are set over the APB port while the solver is idle.
// A model kept here predicts every path node of a solve, and each strobed
// result is compared field by field with the oldest prediction. Directed
// cases come first: register access, a five-node graph, register extremes
// and a 16-node graph. Random phases with varied settings follow.
module tb_top;
    import mgsp_pkg::*;

    localparam int NODES_MAX   = 64;
    localparam int W_BITS      = 16;
    localparam int QUIET_LIMIT = 20000;

    typedef enum logic {
        ACT_WRITE_EDGE = 1'b0,
        ACT_SOLVE      = 1'b1
    } action_t;

    // one path node of a solve, as it leaves the block
    typedef struct packed {
        logic [FIELD_W-1:0] node;
        logic [FIELD_W-1:0] position;
        logic [COST_W-1:0]  cost;
        logic               unreach;
        logic               is_last;
    } path_step_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  action;
    logic [FIELD_W-1:0]    from_node;
    logic [FIELD_W-1:0]    to_node;
    logic [W_BITS-1:0]     weight;
    logic                  result_valid;
    logic [FIELD_W-1:0]    path_node;
    logic [FIELD_W-1:0]    path_position;
    logic [COST_W-1:0]     total_cost;
    logic                  unreachable;
    logic                  last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // mirror of the graph and of the per-node solve state
    int unsigned edge_w [1:NODES_MAX][1:NODES_MAX];
    bit          edge_set [1:NODES_MAX][1:NODES_MAX];
    int unsigned cost_to_sink [1:NODES_MAX];
    int          next_hop [1:NODES_MAX];
    bit          reaches_sink [1:NODES_MAX];

    // register shadows, as last written
    logic [FIELD_W-1:0] cfg_nodes  = NODE_COUNT_RST;
    logic [FIELD_W-1:0] cfg_stages = STAGE_COUNT_RST;
    logic [COST_W-1:0]  cfg_limit  = COST_LIMIT_RST;

    path_step_t expected_path [$];
    int         mismatches = 0;
    int         idle_pct   = 36;
    int         quiet_cycles = 0;

    multistage_graph_shortest_path #(
        .MAX_NODES   (NODES_MAX),
        .WEIGHT_BITS (W_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .from_node     (from_node),
        .to_node       (to_node),
        .weight        (weight),
        .result_valid  (result_valid),
        .path_node     (path_node),
        .path_position (path_position),
        .total_cost    (total_cost),
        .unreachable   (unreachable),
        .last          (last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // -------------------------------------------------------------------------
    // prediction
    // -------------------------------------------------------------------------

    // node and stage counts saturate to 2..NODES_MAX
    function automatic int saturate_count(input logic [FIELD_W-1:0] v);
        if (v < 2)
        begin
            return 2;
        end
        if (v > NODES_MAX)
        begin
            return NODES_MAX;
        end
        return int'(v);
    endfunction

    // backward pass from the sink, then the walk along the decisions
    function automatic void predict_path();
        int          n;
        int          k;
        int          pick;
        int          cur;
        int unsigned best;
        int unsigned sum;
        path_step_t  step;
        n = saturate_count(cfg_nodes);
        k = saturate_count(cfg_stages);
        cost_to_sink[n] = 0;
        reaches_sink[n] = 1'b1;
        next_hop[n]     = n;       // the sink decides for itself
        for (int j = n - 1; j >= 1; j--)
        begin
            best = cfg_limit;
            pick = 0;
            for (int i = j + 1; i <= n; i++)
            begin
                // unreachable successors are never candidates
                if (reaches_sink[i])
                begin
                    sum = edge_w[j][i] + cost_to_sink[i];
                    if (sum < best)
                    begin
                        best = sum;
                        pick = i;
                    end
                end
            end
            if (pick != 0)
            begin
                cost_to_sink[j] = best;
                next_hop[j]     = pick;
                reaches_sink[j] = 1'b1;
            end
            else
            begin
                // no candidate under the limit: cost 0, decision is the sink
                cost_to_sink[j] = 0;
                next_hop[j]     = n;
                reaches_sink[j] = 1'b0;
            end
        end
        cur = 1;
        for (int pos = 1; pos <= k; pos++)
        begin
            if (pos == k)
            begin
                cur = n;
            end
            else if (pos > 1)
            begin
                cur = next_hop[cur];
            end
            step.node     = FIELD_W'(cur);
            step.position = FIELD_W'(pos);
            step.cost     = reaches_sink[1] ? COST_W'(cost_to_sink[1]) : '0;
            step.unreach  = !reaches_sink[1];
            step.is_last  = (pos == k);
            expected_path.push_back(step);
        end
    endfunction

    // weights that give real paths, missing edges and wide values
    function automatic int pick_weight();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 40);
            5, 6:          return 16'hFFFF;
            7:             return 0;
            default:       return $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    // -------------------------------------------------------------------------
    // checking
    // -------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: %s", $time, what);
    endtask

    // every strobed result is taken at the edge that ends its cycle
    always @(posedge clk)
    begin
        path_step_t seen;
        path_step_t want;
        if (rst_n && result_valid)
        begin
            seen.node     = path_node;
            seen.position = path_position;
            seen.cost     = total_cost;
            seen.unreach  = unreachable;
            seen.is_last  = last;
            if (expected_path.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result node %0d position %0d",
                                          seen.node, seen.position));
            end
            else
            begin
                want = expected_path.pop_front();
                if (seen != want)
                begin
                    report_mismatch($sformatf(
                        "got node %0d pos %0d cost %0d unr %0b last %0b, want %0d %0d %0d %0b %0b",
                        seen.node, seen.position, seen.cost, seen.unreach, seen.is_last,
                        want.node, want.position, want.cost, want.unreach, want.is_last));
                end
            end
        end
    end

    // watchdog: cycles in a row with no request, result or register access
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (psel && penable))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout with %0d results outstanding", expected_path.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // -------------------------------------------------------------------------
    // drivers; every task starts and ends at a falling edge
    // -------------------------------------------------------------------------

    // one request; the model is updated at the edge that accepts it
    task automatic send_request(input action_t act, input int from_n, input int to_n,
                                input int w);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start     = 1'b1;
        action    = act;
        from_node = FIELD_W'(from_n);
        to_node   = FIELD_W'(to_n);
        weight    = W_BITS'(w);
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        if (act == ACT_SOLVE)
        begin
            predict_path();
        end
        else if (from_n >= 1 && from_n <= NODES_MAX && to_n >= 1 && to_n <= NODES_MAX)
        begin
            // out-of-range node numbers are dropped by the block
            edge_w[from_n][to_n]   = w & ((1 << W_BITS) - 1);
            edge_set[from_n][to_n] = 1'b1;
        end
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [APB_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_NODE_COUNT:  cfg_nodes  = data[FIELD_W-1:0];
            REG_STAGE_COUNT: cfg_stages = data[FIELD_W-1:0];
            REG_COST_LIMIT:  cfg_limit  = data[COST_W-1:0];
            default:         ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // read one register back and compare with its shadow
    task automatic check_register(input logic [REG_IDX_W-1:0] idx);
        logic [APB_DATA_W-1:0] want;
        logic [APB_DATA_W-1:0] got;
        case (idx)
            REG_NODE_COUNT:  want = APB_DATA_W'(cfg_nodes);
            REG_STAGE_COUNT: want = APB_DATA_W'(cfg_stages);
            default:         want = APB_DATA_W'(cfg_limit);
        endcase
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        got = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got !== want)
        begin
            report_mismatch($sformatf("register %0d reads %0h, want %0h", idx, got, want));
        end
    endtask

    // hold off until every predicted result has arrived and the block is idle
    task automatic wait_drained();
        while (expected_path.size() != 0 || busy)
        begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
    endtask

    // write any edge a solve over n nodes would read and that is still unset
    task automatic fill_edges(input int n);
        for (int j = 1; j < n; j++)
        begin
            for (int i = j + 1; i <= n; i++)
            begin
                if (!edge_set[j][i])
                begin
                    send_request(ACT_WRITE_EDGE, j, i, pick_weight());
                end
            end
        end
    endtask

    // registers change only with the block idle
    task automatic configure(input int nodes, input int stages, input int limit);
        wait_drained();
        write_register(REG_NODE_COUNT, APB_DATA_W'(nodes));
        write_register(REG_STAGE_COUNT, APB_DATA_W'(stages));
        write_register(REG_COST_LIMIT, APB_DATA_W'(limit));
        fill_edges(saturate_count(cfg_nodes));
    endtask

    task automatic run_solve();
        send_request(ACT_SOLVE, $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
    endtask

    // -------------------------------------------------------------------------
    // tests
    // -------------------------------------------------------------------------

    // reset values, extremes and masking of the upper data bits
    task automatic test_register_access();
        check_register(REG_NODE_COUNT);
        check_register(REG_STAGE_COUNT);
        check_register(REG_COST_LIMIT);
        write_register(REG_NODE_COUNT, 32'h0000_007F);
        check_register(REG_NODE_COUNT);
        write_register(REG_NODE_COUNT, 32'hFFFF_FFC5);
        check_register(REG_NODE_COUNT);
        write_register(REG_STAGE_COUNT, 32'h0000_0000);
        check_register(REG_STAGE_COUNT);
        write_register(REG_STAGE_COUNT, 32'hFFFF_FF7F);
        check_register(REG_STAGE_COUNT);
        write_register(REG_COST_LIMIT, 32'hFFFF_FFFF);
        check_register(REG_COST_LIMIT);
        write_register(REG_COST_LIMIT, 32'h0000_0000);
        check_register(REG_COST_LIMIT);
    endtask

    // five nodes; node 4 has only a missing edge, so it is unreachable and
    // must be skipped by every node before it
    task automatic test_small_graph();
        int hand_edges [10][3] = '{
            '{1, 2, 3},  '{1, 3, 10}, '{1, 4, 0},      '{1, 5, 50},
            '{2, 3, 0},  '{2, 4, 1},  '{2, 5, 60},
            '{3, 4, 0},  '{3, 5, 7},  '{4, 5, 16'hFFFF}
        };
        foreach (hand_edges[e])
        begin
            send_request(ACT_WRITE_EDGE, hand_edges[e][0], hand_edges[e][1],
                         hand_edges[e][2]);
        end
        configure(5, 5, 100);
        // dropped writes aimed at node 0 and past the last node
        send_request(ACT_WRITE_EDGE, 0, 3, 0);
        send_request(ACT_WRITE_EDGE, 3, 0, 0);
        send_request(ACT_WRITE_EDGE, 127, 127, 0);
        send_request(ACT_WRITE_EDGE, 65, 2, 0);
        send_request(ACT_WRITE_EDGE, 2, 65, 0);
        run_solve();
        // path cut short: the last stage is forced to the sink
        configure(5, 3, 100);
        run_solve();
    endtask

    // saturated counts, zero and full limits, path parked at the sink
    task automatic test_register_extremes();
        configure(1, 1, 100);
        run_solve();
        configure(0, 127, 16'hFFFF);
        run_solve();
        configure(5, 4, 0);
        run_solve();
        configure(5, 9, 100);
        run_solve();
        configure(5, 5, 1);
        run_solve();
        configure(6, 2, 16'hFFFF);
        run_solve();
    endtask

    // widest graph of the run, with long and saturated paths
    task automatic test_wide_graph();
        configure(16, 64, 16'hFFFF);
        run_solve();
        configure(16, 127, 300);
        run_solve();
        configure(16, 3, 40);
        run_solve();
    endtask

    // random settings per phase, mostly well-formed edge loads and solves
    task automatic test_random();
        int n;
        int nodes;
        int stages;
        int limit;
        int pick;
        for (int phase = 0; phase < 13; phase++)
        begin
            // two phases run back to back with no gaps at all
            idle_pct = (phase == 4 || phase == 5) ? 0 : 36;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: nodes = $urandom_range(2, 8);
                8:                nodes = $urandom_range(0, 1);
                default:          nodes = $urandom_range(9, 16);
            endcase
            case ($urandom_range(0, 7))
                0, 1, 2, 3, 4: stages = $urandom_range(2, 10);
                5:             stages = $urandom_range(0, 1);
                6:             stages = $urandom_range(11, 64);
                default:       stages = $urandom_range(65, 127);
            endcase
            case ($urandom_range(0, 7))
                0:       limit = 0;
                1:       limit = $urandom_range(1, 10);
                2:       limit = 16'hFFFF;
                3:       limit = $urandom_range(0, 16'hFFFF);
                default: limit = $urandom_range(20, 200);
            endcase
            configure(nodes, stages, limit);
            n = saturate_count(cfg_nodes);
            for (int c = 0; c < 17; c++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    send_request(ACT_WRITE_EDGE, $urandom_range(1, n), $urandom_range(1, n),
                                 pick_weight());
                end
                else if (pick < 70)
                begin
                    send_request(ACT_WRITE_EDGE, $urandom_range(1, NODES_MAX),
                                 $urandom_range(1, NODES_MAX), $urandom_range(0, 16'hFFFF));
                end
                else if (pick < 76)
                begin
                    // noise: a node number of 0 or past the last node
                    send_request(ACT_WRITE_EDGE,
                                 $urandom_range(0, 1) ? 0 : $urandom_range(65, 127),
                                 $urandom_range(0, 127), $urandom_range(0, 16'hFFFF));
                end
                else
                begin
                    // now and then the sender waits out every pending result
                    if ($urandom_range(0, 9) == 0)
                    begin
                        wait_drained();
                    end
                    run_solve();
                end
            end
        end
        idle_pct = 36;
    endtask

    // -------------------------------------------------------------------------
    // sequence
    // -------------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        action    = ACT_WRITE_EDGE;
        from_node = '0;
        to_node   = '0;
        weight    = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_register_access();
        test_small_graph();
        test_register_extremes();
        test_wide_graph();
        test_random();

        wait_drained();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/mgsp_pkg.sv
src/multistage_graph_shortest_path.sv
src/mgsp_checker.sv
sim/tb_top.sv
